// ===== hdl/spvfe_pkg.sv =====
`default_nettype none
package spvfe_pkg;

  // Fixed-point format of the datapath
  localparam int unsigned FRAC_BITS    = 16;
  localparam int unsigned CORDIC_STEPS = 16;
  // Register stages of the sine/cosine unit: 4 reduction stages, the steps, one output stage
  localparam int unsigned SC_LAT       = CORDIC_STEPS + 5;

  // Angle reduction constants (Q16.16)
  localparam logic [18:0] PI_Q    = 19'd205887;
  localparam logic [18:0] TWO_PI  = 19'd411774;
  // 2^31 mod two_pi, removes the unsigned offset of the input angle
  localparam logic [19:0] MOD_OFS = 20'd82238;
  // floor(2^51 / two_pi), reciprocal for the modulo
  localparam logic [63:0] RECIP   = (64'd1 << 51) / 64'd411774;
  localparam int unsigned RECIP_SH = 51;

  // CORDIC constants (Q2.30)
  localparam logic signed [33:0] HALF_PI_CQ = 34'sd1686629713;
  localparam logic signed [33:0] PI_CQ      = 34'sd3373259426;
  localparam logic signed [33:0] GAIN_CQ    = 34'sd652032874;

  // Configuration register map
  typedef enum logic [2:0] {
    REG_CENTER_X     = 3'd0,
    REG_CENTER_Y     = 3'd1,
    REG_ROTATION     = 3'd2,
    REG_SPATIAL_FREQ = 3'd3,
    REG_PHASE_OFFSET = 3'd4,
    REG_AMPLITUDE    = 3'd5
  } cfg_reg_e;

  // Saturate a widened sum to 32 bits signed
  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sd2147483647) begin
      r = 32'sh7fff_ffff;
    end else if (v < -34'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // arctan(2^-i) in Q2.30
  function automatic logic signed [33:0] atan_q30(input int unsigned i);
    logic signed [33:0] r;
    case (i)
      0:       r = 34'sh03243F6A8;
      1:       r = 34'sh01DAC6705;
      2:       r = 34'sh00FADBAFC;
      3:       r = 34'sh007F56EA6;
      4:       r = 34'sh003FEAB76;
      5:       r = 34'sh001FFD55B;
      6:       r = 34'sh000FFFAAA;
      7:       r = 34'sh0007FFF55;
      8:       r = 34'sh0003FFFEA;
      9:       r = 34'sh0001FFFFD;
      10:      r = 34'sh0000FFFFF;
      11:      r = 34'sh00007FFFF;
      12:      r = 34'sh00003FFFF;
      13:      r = 34'sh00001FFFF;
      14:      r = 34'sh00000FFFF;
      15:      r = 34'sh000007FFF;
      16:      r = 34'sh000003FFF;
      17:      r = 34'sh000001FFF;
      18:      r = 34'sh000000FFF;
      19:      r = 34'sh0000007FF;
      20:      r = 34'sh0000003FF;
      21:      r = 34'sh0000001FF;
      22:      r = 34'sh0000000FF;
      23:      r = 34'sh00000007F;
      default: r = 34'sh0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/spvfe_mulq.sv =====
`default_nettype none
// Fixed-point multiply: exact product, round half away from zero, saturate.
// Two register stages.
module spvfe_mulq (
  input  wire logic               clk_i,
  input  wire logic signed [31:0] a_i,
  input  wire logic signed [31:0] b_i,
  output logic signed [31:0]      res_o
);

  logic signed [63:0] prod_q;
  logic [63:0]        mag;
  logic [63:0]        rnd;
  logic [47:0]        shr;
  logic signed [31:0] res_d;

  // Full product
  always_ff @(posedge clk_i) begin
    prod_q <= 64'(a_i) * 64'(b_i);
  end

  // Round on magnitude, then saturate with the sign
  always_comb begin
    mag = prod_q[63] ? 64'(-prod_q) : 64'(prod_q);
    rnd = mag + (64'd1 << (spvfe_pkg::FRAC_BITS - 1));
    shr = 48'(rnd >> spvfe_pkg::FRAC_BITS);
    if (prod_q[63]) begin
      res_d = (shr >= 48'h8000_0000) ? 32'sh8000_0000 : -$signed(shr[31:0]);
    end else begin
      res_d = (shr >= 48'h8000_0000) ? 32'sh7fff_ffff : $signed(shr[31:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    res_o <= res_d;
  end

endmodule
`default_nettype wire

// ===== hdl/spvfe_sincos.sv =====
`default_nettype none
// Pipelined sine/cosine: reduction into (-pi, pi], quadrant fold, CORDIC.
// Has spvfe_pkg::SC_LAT register stages and takes one angle per cycle.
module spvfe_sincos (
  input  wire logic               clk_i,
  input  wire logic signed [31:0] ang_i,
  output logic signed [31:0]      sin_o,
  output logic signed [31:0]      cos_o
);

  localparam int unsigned N = spvfe_pkg::CORDIC_STEPS;

  logic [64:0]        prod_q;
  logic [31:0]        u_q;
  logic [13:0]        quo;
  logic [31:0]        qt;
  logic [31:0]        rem_full;
  logic [19:0]        rem_q;
  logic [19:0]        r1;
  logic [19:0]        dif;
  logic [19:0]        r2_d;
  logic [19:0]        r2_q;
  logic signed [19:0] r3;
  logic signed [33:0] z0;
  logic signed [33:0] zf_d;
  logic               fl_d;

  logic signed [33:0] x_q [N+1];
  logic signed [33:0] y_q [N+1];
  logic signed [33:0] z_q [N+1];
  logic               f_q [N+1];

  logic signed [33:0] xf;
  logic signed [33:0] yf;
  logic signed [33:0] cr;
  logic signed [33:0] sr;

  // Stage 1: offset angle to unsigned, multiply by reciprocal of two pi
  always_ff @(posedge clk_i) begin
    u_q    <= {~ang_i[31], ang_i[30:0]};
    prod_q <= 65'({~ang_i[31], ang_i[30:0]}) * 65'(spvfe_pkg::RECIP[32:0]);
  end

  // Stage 2: remainder, within two periods
  always_comb begin
    quo      = prod_q[spvfe_pkg::RECIP_SH +: 14];
    qt       = 32'(quo) * 32'(spvfe_pkg::TWO_PI);
    rem_full = u_q - qt;
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_full[19:0];
  end

  // Stage 3: final correction and removal of the unsigned offset
  always_comb begin
    r1   = (rem_q >= 20'(spvfe_pkg::TWO_PI)) ? rem_q - 20'(spvfe_pkg::TWO_PI) : rem_q;
    dif  = r1 - spvfe_pkg::MOD_OFS;
    r2_d = dif[19] ? dif + 20'(spvfe_pkg::TWO_PI) : dif;
  end

  always_ff @(posedge clk_i) begin
    r2_q <= r2_d;
  end

  // Stage 4: center into (-pi, pi], scale to Q30, fold to the right half plane
  always_comb begin
    r3 = (r2_q > 20'(spvfe_pkg::PI_Q)) ? $signed(r2_q - 20'(spvfe_pkg::TWO_PI))
                                       : $signed(r2_q);
    z0 = 34'(r3) <<< 14;
    if (z0 > spvfe_pkg::HALF_PI_CQ) begin
      zf_d = z0 - spvfe_pkg::PI_CQ;
      fl_d = 1'b1;
    end else if (z0 < -spvfe_pkg::HALF_PI_CQ) begin
      zf_d = z0 + spvfe_pkg::PI_CQ;
      fl_d = 1'b1;
    end else begin
      zf_d = z0;
      fl_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q[0] <= spvfe_pkg::GAIN_CQ;
    y_q[0] <= 34'sd0;
    z_q[0] <= zf_d;
    f_q[0] <= fl_d;
  end

  // CORDIC rotation steps, one per stage
  for (genvar k = 0; k < N; k++) begin : g_step
    always_ff @(posedge clk_i) begin
      f_q[k+1] <= f_q[k];
      if (!z_q[k][33]) begin
        x_q[k+1] <= x_q[k] - (y_q[k] >>> k);
        y_q[k+1] <= y_q[k] + (x_q[k] >>> k);
        z_q[k+1] <= z_q[k] - spvfe_pkg::atan_q30(k);
      end else begin
        x_q[k+1] <= x_q[k] + (y_q[k] >>> k);
        y_q[k+1] <= y_q[k] - (x_q[k] >>> k);
        z_q[k+1] <= z_q[k] + spvfe_pkg::atan_q30(k);
      end
    end
  end

  // Unfold and round to Q16.16
  always_comb begin
    xf = f_q[N] ? -x_q[N] : x_q[N];
    yf = f_q[N] ? -y_q[N] : y_q[N];
    cr = (xf + 34'sd8192) >>> 14;
    sr = (yf + 34'sd8192) >>> 14;
  end

  always_ff @(posedge clk_i) begin
    cos_o <= cr[31:0];
    sin_o <= sr[31:0];
  end

endmodule
`default_nettype wire

// ===== hdl/sine_path_vector_field_eval.sv =====
// Sinusoidal path field evaluator.
// Write the six path registers through cfg_we_i / cfg_idx_i / cfg_wdata_i
// while no transaction is in flight; index 0..5 selects center_x, center_y,
// rotation, spatial_freq, phase_offset, amplitude, other indexes are ignored.
// A transaction starts at a clock edge with start high and busy low; busy
// stays low, so a new position may be issued every cycle.
// Each position yields one result: phi, gradient and Hessian, presented for
// one cycle with done_o high. Throughput is one position per cycle;
// latency is set by two pipelined sine/cosine units (21 stages each: angle
// reduction, 16 CORDIC steps and an output stage) and five chained
// two-stage fixed-point multiplies. The receiver takes every result as it
// appears; results are never held. Reset clears the path registers to zero
// and drops all transactions in flight. Arithmetic is Q16.16 with rounded,
// saturated products.
`default_nettype none
module sine_path_vector_field_eval (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_idx_i,
  input  wire logic [31:0]        cfg_wdata_i,
  input  wire logic signed [31:0] pos_x_i,
  input  wire logic signed [31:0] pos_y_i,
  output logic                    done_o,
  output logic signed [31:0]      phi_out_o,
  output logic signed [31:0]      grad_x_o,
  output logic signed [31:0]      grad_y_o,
  output logic signed [31:0]      hess_11_o,
  output logic signed [31:0]      hess_12_o,
  output logic signed [31:0]      hess_21_o,
  output logic signed [31:0]      hess_22_o
);

  // Pipeline timing, in edges after the start edge
  localparam int unsigned T_ROT = spvfe_pkg::SC_LAT - 1;
  localparam int unsigned T_XS  = T_ROT + 3;
  localparam int unsigned T_ANG = T_XS + 3;
  localparam int unsigned T_SG  = T_ANG + spvfe_pkg::SC_LAT;
  localparam int unsigned T_OUT = T_SG + 7;

  localparam int unsigned N_DXY = T_ROT + 1;
  localparam int unsigned N_RSC = T_SG + 4 - T_ROT;
  localparam int unsigned N_YS  = T_SG + 2 - T_XS;
  localparam int unsigned N_AW  = T_SG - T_ROT - 2;
  localparam int unsigned N_PG  = 4;

  // Path registers
  logic signed [31:0] center_x_q;
  logic signed [31:0] center_y_q;
  logic signed [18:0] rotation_q;
  logic signed [31:0] freq_q;
  logic signed [31:0] offset_q;
  logic signed [31:0] amp_q;

  logic               accept;
  logic [T_OUT:0]     vld_q;

  logic signed [31:0] dx_q [N_DXY];
  logic signed [31:0] dy_q [N_DXY];
  logic signed [31:0] sa_w;
  logic signed [31:0] ca_w;
  logic signed [31:0] sa_q [N_RSC];
  logic signed [31:0] ca_q [N_RSC];

  logic signed [31:0] aw;
  logic signed [31:0] aww;
  logic signed [31:0] p_dxs;
  logic signed [31:0] p_dyc;
  logic signed [31:0] p_dxc;
  logic signed [31:0] p_dys;
  logic signed [31:0] awsa;
  logic signed [31:0] awca;
  logic signed [31:0] xs_q;
  logic signed [31:0] ys_q;
  logic signed [31:0] ys_d_q [N_YS];
  logic signed [31:0] awsa_q [N_AW];
  logic signed [31:0] awca_q [N_AW];
  logic signed [31:0] wxs;
  logic signed [31:0] ang_q;
  logic signed [31:0] sg_w;
  logic signed [31:0] cg_w;

  logic signed [31:0] sv;
  logic signed [31:0] asg;
  logic signed [31:0] gxt;
  logic signed [31:0] gyt;
  logic signed [31:0] svsa;
  logic signed [31:0] svca;
  logic signed [31:0] h11;
  logic signed [31:0] h12m;
  logic signed [31:0] h22;

  logic signed [31:0] phi_q [N_PG];
  logic signed [31:0] gx_q  [N_PG];
  logic signed [31:0] gy_q  [N_PG];

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= '0;
      center_y_q <= '0;
      rotation_q <= '0;
      freq_q     <= '0;
      offset_q   <= '0;
      amp_q      <= '0;
    end else if (cfg_we_i) begin
      case (spvfe_pkg::cfg_reg_e'(cfg_idx_i))
        spvfe_pkg::REG_CENTER_X:     center_x_q <= cfg_wdata_i;
        spvfe_pkg::REG_CENTER_Y:     center_y_q <= cfg_wdata_i;
        spvfe_pkg::REG_ROTATION:     rotation_q <= cfg_wdata_i[18:0];
        spvfe_pkg::REG_SPATIAL_FREQ: freq_q     <= cfg_wdata_i;
        spvfe_pkg::REG_PHASE_OFFSET: offset_q   <= cfg_wdata_i;
        spvfe_pkg::REG_AMPLITUDE:    amp_q      <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Valid bits travel with the transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[T_OUT-1:0], accept};
    end
  end

  // Offsets from the path center, delayed to meet the rotation sine/cosine
  always_ff @(posedge clk_i) begin
    dx_q[0] <= spvfe_pkg::sat32(34'(pos_x_i) - 34'(center_x_q));
    dy_q[0] <= spvfe_pkg::sat32(34'(pos_y_i) - 34'(center_y_q));
    for (int i = 1; i < N_DXY; i++) begin
      dx_q[i] <= dx_q[i-1];
      dy_q[i] <= dy_q[i-1];
    end
  end

  // Rotation sine/cosine, computed continuously from the rotation register
  spvfe_sincos u_sc_rot (
    .clk_i (clk_i),
    .ang_i (32'(rotation_q)),
    .sin_o (sa_w),
    .cos_o (ca_w)
  );

  always_ff @(posedge clk_i) begin
    sa_q[0] <= sa_w;
    ca_q[0] <= ca_w;
    for (int i = 1; i < N_RSC; i++) begin
      sa_q[i] <= sa_q[i-1];
      ca_q[i] <= ca_q[i-1];
    end
  end

  // Amplitude products depend on the path registers only
  spvfe_mulq u_m_aw  (.clk_i(clk_i), .a_i(amp_q), .b_i(freq_q), .res_o(aw));
  spvfe_mulq u_m_aww (.clk_i(clk_i), .a_i(aw),    .b_i(freq_q), .res_o(aww));

  // Rotate the offset into the path frame
  spvfe_mulq u_m_dxs  (.clk_i(clk_i), .a_i(dx_q[T_ROT]), .b_i(sa_w), .res_o(p_dxs));
  spvfe_mulq u_m_dyc  (.clk_i(clk_i), .a_i(dy_q[T_ROT]), .b_i(ca_w), .res_o(p_dyc));
  spvfe_mulq u_m_dxc  (.clk_i(clk_i), .a_i(dx_q[T_ROT]), .b_i(ca_w), .res_o(p_dxc));
  spvfe_mulq u_m_dys  (.clk_i(clk_i), .a_i(dy_q[T_ROT]), .b_i(sa_w), .res_o(p_dys));
  spvfe_mulq u_m_awsa (.clk_i(clk_i), .a_i(aw),          .b_i(sa_w), .res_o(awsa));
  spvfe_mulq u_m_awca (.clk_i(clk_i), .a_i(aw),          .b_i(ca_w), .res_o(awca));

  always_ff @(posedge clk_i) begin
    xs_q <= spvfe_pkg::sat32(34'(p_dxs) - 34'(p_dyc));
    ys_q <= spvfe_pkg::sat32(34'(spvfe_pkg::sat32(-34'(p_dxc))) - 34'(p_dys));
  end

  // Phase of the sinusoid
  spvfe_mulq u_m_wxs (.clk_i(clk_i), .a_i(freq_q), .b_i(xs_q), .res_o(wxs));

  always_ff @(posedge clk_i) begin
    ang_q <= spvfe_pkg::sat32(34'(wxs) + 34'(offset_q));
  end

  spvfe_sincos u_sc_ang (
    .clk_i (clk_i),
    .ang_i (ang_q),
    .sin_o (sg_w),
    .cos_o (cg_w)
  );

  // Carry path-frame values across the phase sine/cosine
  always_ff @(posedge clk_i) begin
    ys_d_q[0] <= ys_q;
    awsa_q[0] <= awsa;
    awca_q[0] <= awca;
    for (int i = 1; i < N_YS; i++) begin
      ys_d_q[i] <= ys_d_q[i-1];
    end
    for (int i = 1; i < N_AW; i++) begin
      awsa_q[i] <= awsa_q[i-1];
      awca_q[i] <= awca_q[i-1];
    end
  end

  // Products on the phase sine/cosine
  spvfe_mulq u_m_sv  (.clk_i(clk_i), .a_i(aww),            .b_i(sg_w), .res_o(sv));
  spvfe_mulq u_m_asg (.clk_i(clk_i), .a_i(amp_q),          .b_i(sg_w), .res_o(asg));
  spvfe_mulq u_m_gxt (.clk_i(clk_i), .a_i(awsa_q[N_AW-1]), .b_i(cg_w), .res_o(gxt));
  spvfe_mulq u_m_gyt (.clk_i(clk_i), .a_i(awca_q[N_AW-1]), .b_i(cg_w), .res_o(gyt));

  // Function value and gradient
  always_ff @(posedge clk_i) begin
    phi_q[0] <= spvfe_pkg::sat32(34'(ys_d_q[N_YS-1]) - 34'(asg));
    gx_q[0]  <= spvfe_pkg::sat32(
                  34'(spvfe_pkg::sat32(-34'(ca_q[T_SG+1-T_ROT]))) - 34'(gxt));
    gy_q[0]  <= spvfe_pkg::sat32(
                  34'(spvfe_pkg::sat32(-34'(sa_q[T_SG+1-T_ROT]))) + 34'(gyt));
    for (int i = 1; i < N_PG; i++) begin
      phi_q[i] <= phi_q[i-1];
      gx_q[i]  <= gx_q[i-1];
      gy_q[i]  <= gy_q[i-1];
    end
  end

  // Hessian
  spvfe_mulq u_m_svsa (.clk_i(clk_i), .a_i(sv), .b_i(sa_q[T_SG+1-T_ROT]), .res_o(svsa));
  spvfe_mulq u_m_svca (.clk_i(clk_i), .a_i(sv), .b_i(ca_q[T_SG+1-T_ROT]), .res_o(svca));
  spvfe_mulq u_m_h11  (.clk_i(clk_i), .a_i(svsa), .b_i(sa_q[N_RSC-1]), .res_o(h11));
  spvfe_mulq u_m_h12  (.clk_i(clk_i), .a_i(svsa), .b_i(ca_q[N_RSC-1]), .res_o(h12m));
  spvfe_mulq u_m_h22  (.clk_i(clk_i), .a_i(svca), .b_i(ca_q[N_RSC-1]), .res_o(h22));

  // Result registers
  always_ff @(posedge clk_i) begin
    phi_out_o <= phi_q[N_PG-1];
    grad_x_o  <= gx_q[N_PG-1];
    grad_y_o  <= gy_q[N_PG-1];
    hess_11_o <= h11;
    hess_12_o <= spvfe_pkg::sat32(-34'(h12m));
    hess_21_o <= spvfe_pkg::sat32(-34'(h12m));
    hess_22_o <= h22;
  end

  assign done_o = vld_q[T_OUT];

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
`default_nettype none
module tb;

  localparam longint WMAX      = 64'sd2147483647;
  localparam longint PI_FX     = 64'sd205887;
  localparam longint HALF_PI_C = 64'sd1686629713;
  localparam longint PI_C      = 64'sd3373259426;
  localparam longint GAIN_C    = 64'sd652032874;
  localparam int     N_STEPS   = 16;
  localparam int     DRAIN     = 80;
  localparam int     MAX_CYC   = 200000;
  localparam int     N_PHASES  = 10;
  localparam int     PHASE_LEN = 142;
  // index that selects no register
  localparam logic [2:0] IDX_NONE_A = 3'd6;
  localparam logic [2:0] IDX_NONE_B = 3'd7;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
  } pos_t;

  typedef struct {
    logic [31:0] f [7];
  } field_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [31:0] cfg_wdata_i = '0;
  logic signed [31:0] pos_x_i = '0;
  logic signed [31:0] pos_y_i = '0;
  logic done_o;
  logic signed [31:0] phi_out_o, grad_x_o, grad_y_o;
  logic signed [31:0] hess_11_o, hess_12_o, hess_21_o, hess_22_o;

  // path register copy
  longint c_x = 0, c_y = 0, c_rot = 0, c_w = 0, c_off = 0, c_amp = 0;

  pos_t   pending_q [$];
  field_t field_q [$];
  int     sender_idle_pct = 14;
  int     n_err = 0;
  int     cyc = 0;
  bit     accepted = 1'b0;

  string names [7] = '{"phi_out", "grad_x", "grad_y", "hess_11", "hess_12",
                       "hess_21", "hess_22"};

  sine_path_vector_field_eval DUT (
    .clk_i, .rst_ni, .start, .busy, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .pos_x_i, .pos_y_i, .done_o, .phi_out_o, .grad_x_o, .grad_y_o,
    .hess_11_o, .hess_12_o, .hess_21_o, .hess_22_o
  );

  always #5 clk_i = ~clk_i;

  function automatic longint clamp(longint v);
    if (v > WMAX) return WMAX;
    if (v < -WMAX - 1) return -WMAX - 1;
    return v;
  endfunction

  // rounded (ties away from zero), saturated fixed-point product
  function automatic longint fmul(longint a, longint b);
    bit neg;
    longint m, lim;
    neg = (a < 0) != (b < 0);
    m = ((a < 0 ? -a : a) * (b < 0 ? -b : b) + 64'sd32768) >>> 16;
    lim = WMAX + (neg ? 1 : 0);
    if (m > lim) m = lim;
    return neg ? -m : m;
  endfunction

  // reduce into (-pi, pi] then rotate with CORDIC
  function automatic void sin_cos(longint ang, output longint s, output longint c);
    longint atan_c [N_STEPS] = '{
      64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
      64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
      64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
      64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF};
    longint r, z, x, y, t;
    bit flip;
    flip = 1'b0;
    r = ang % (2 * PI_FX);
    if (r < 0) r += 2 * PI_FX;
    if (r > PI_FX) r -= 2 * PI_FX;
    z = r <<< 14;
    x = GAIN_C;
    y = 0;
    if (z > HALF_PI_C) begin
      z -= PI_C;
      flip = 1'b1;
    end else if (z < -HALF_PI_C) begin
      z += PI_C;
      flip = 1'b1;
    end
    for (int i = 0; i < N_STEPS; i++) begin
      if (z >= 0) begin
        t = x - (y >>> i); y = y + (x >>> i); x = t; z -= atan_c[i];
      end else begin
        t = x + (y >>> i); y = y - (x >>> i); x = t; z += atan_c[i];
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = clamp((x + 64'sd8192) >>> 14);
    s = clamp((y + 64'sd8192) >>> 14);
  endfunction

  // phi, gradient and Hessian for one position
  function automatic field_t eval_field(logic signed [31:0] px, logic signed [31:0] py);
    field_t e;
    longint sr, cr, sg, cg, dx, dy, xs, ys, ang, aw, aww, sv, h12;
    sin_cos(c_rot, sr, cr);
    dx = clamp(longint'(px) - c_x);
    dy = clamp(longint'(py) - c_y);
    xs = clamp(fmul(dx, sr) - fmul(dy, cr));
    ys = clamp(clamp(-fmul(dx, cr)) - fmul(dy, sr));
    ang = clamp(fmul(c_w, xs) + c_off);
    sin_cos(ang, sg, cg);
    aw = fmul(c_amp, c_w);
    aww = fmul(aw, c_w);
    sv = fmul(aww, sg);
    h12 = clamp(-fmul(fmul(sv, sr), cr));
    e.f[0] = 32'(clamp(ys - fmul(c_amp, sg)));
    e.f[1] = 32'(clamp(clamp(-cr) - fmul(fmul(aw, sr), cg)));
    e.f[2] = 32'(clamp(clamp(-sr) + fmul(fmul(aw, cr), cg)));
    e.f[3] = 32'(fmul(fmul(sv, sr), sr));
    e.f[4] = 32'(h12);
    e.f[5] = 32'(h12);
    e.f[6] = 32'(fmul(fmul(sv, cr), cr));
    return e;
  endfunction

  // accept transactions, track register writes, check results
  always @(posedge clk_i) begin
    field_t got, exp_f;
    cyc <= cyc + 1;
    if (cyc > MAX_CYC) begin
      $display("TB_ERROR");
      $finish;
    end
    accepted <= start && !busy;
    if (rst_ni && cfg_we_i) begin
      case (cfg_idx_i)
        spvfe_pkg::REG_CENTER_X:     c_x = longint'(signed'(cfg_wdata_i));
        spvfe_pkg::REG_CENTER_Y:     c_y = longint'(signed'(cfg_wdata_i));
        spvfe_pkg::REG_ROTATION:     c_rot = longint'(signed'(cfg_wdata_i[18:0]));
        spvfe_pkg::REG_SPATIAL_FREQ: c_w = longint'(signed'(cfg_wdata_i));
        spvfe_pkg::REG_PHASE_OFFSET: c_off = longint'(signed'(cfg_wdata_i));
        spvfe_pkg::REG_AMPLITUDE:    c_amp = longint'(signed'(cfg_wdata_i));
        default: ;
      endcase
    end
    if (rst_ni && start && !busy) field_q.push_back(eval_field(pos_x_i, pos_y_i));
    if (rst_ni && done_o) begin
      got.f = '{phi_out_o, grad_x_o, grad_y_o, hess_11_o, hess_12_o, hess_21_o,
                hess_22_o};
      if (field_q.size() == 0) begin
        $error("result with no transaction outstanding");
        n_err++;
      end else begin
        exp_f = field_q.pop_front();
        for (int i = 0; i < 7; i++) begin
          if (got.f[i] !== exp_f.f[i]) begin
            $error("%s: expected %0d got %0d", names[i], signed'(exp_f.f[i]),
                   signed'(got.f[i]));
            n_err++;
          end
        end
      end
    end
  end

  // drive positions from the pending queue
  always @(negedge clk_i) begin
    if (rst_ni && (!start || accepted)) begin
      if (pending_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        pos_t p;
        p = pending_q.pop_front();
        pos_x_i <= p.x;
        pos_y_i <= p.y;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_path(logic [31:0] cx, logic [31:0] cy, logic [31:0] rot,
                          logic [31:0] w, logic [31:0] off, logic [31:0] amp);
    write_reg(spvfe_pkg::REG_CENTER_X, cx);
    write_reg(spvfe_pkg::REG_CENTER_Y, cy);
    write_reg(spvfe_pkg::REG_ROTATION, rot);
    write_reg(spvfe_pkg::REG_SPATIAL_FREQ, w);
    write_reg(spvfe_pkg::REG_PHASE_OFFSET, off);
    write_reg(spvfe_pkg::REG_AMPLITUDE, amp);
  endtask

  task automatic drain();
    while (pending_q.size() != 0 || start || field_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  function automatic logic [31:0] sgn_rand(int unsigned mag);
    return $urandom_range(mag) * ($urandom_range(1) ? 1 : -1);
  endfunction

  // mostly positions near the path center, some over the full range
  function automatic pos_t rand_pos();
    pos_t p;
    if ($urandom_range(9) < 3) begin
      p.x = $urandom();
      p.y = $urandom();
    end else begin
      p.x = 32'(c_x + longint'(signed'(sgn_rand(1 << 22))));
      p.y = 32'(c_y + longint'(signed'(sgn_rand(1 << 22))));
    end
    return p;
  endfunction

  initial begin
    logic [31:0] ext [4] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff};
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset registers, then extremes and a gentle path
    foreach (ext[i]) foreach (ext[j]) pending_q.push_back('{ext[i], ext[j]});
    drain();
    set_path(32'h0001_0000, 32'hffff_0000, 32'd51472, 32'h0001_0000,
             32'h0000_8000, 32'h0002_0000);
    pending_q.push_back('{32'h0001_0000, 32'hffff_0000});
    pending_q.push_back('{32'h0003_0000, 32'h0002_0000});
    pending_q.push_back('{32'h8000_0000, 32'h7fff_ffff});
    drain();
    // rotation beyond pi, extreme gains, huge phase
    set_path(32'h8000_0000, 32'h7fff_ffff, 32'h0004_0000, 32'h7fff_ffff,
             32'h7fff_ffff, 32'h8000_0000);
    write_reg(IDX_NONE_A, 32'h1234_5678);
    write_reg(IDX_NONE_B, 32'hffff_ffff);
    foreach (ext[i]) pending_q.push_back('{ext[i], ext[3 - i]});
    drain();
    set_path(32'h7fff_ffff, 32'h8000_0000, 32'h0007_ffff, 32'h8000_0000,
             32'h8000_0000, 32'h7fff_ffff);
    foreach (ext[i]) pending_q.push_back('{ext[i], ext[i]});
    drain();

    // random phases, sender gap rate changes across them
    for (int ph = 0; ph < N_PHASES; ph++) begin
      sender_idle_pct = (ph < 3) ? 14 : (ph < 6) ? 62 : 0;
      if (ph % 4 == 3) begin
        set_path($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                 $urandom());
      end else begin
        set_path(sgn_rand(1 << 24), sgn_rand(1 << 24), $urandom_range((1 << 19) - 1),
                 sgn_rand(1 << 18), $urandom(), sgn_rand(1 << 20));
      end
      for (int k = 0; k < PHASE_LEN; k++) pending_q.push_back(rand_pos());
      drain();
    end

    if (n_err == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== files.f =====
hdl/spvfe_pkg.sv
hdl/spvfe_mulq.sv
hdl/spvfe_sincos.sv
hdl/sine_path_vector_field_eval.sv
tb/sv/tb.sv
